/* rtl/core/codon_to_amino_translator_defines.svh */
// Assertion macros for the translator RTL.
`ifndef CODON_TO_AMINO_TRANSLATOR_DEFINES_SVH
`define CODON_TO_AMINO_TRANSLATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define CTAT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define CTAT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/ctat_pkg.sv */
package ctat_pkg;

  // ASCII codes used by the translation
  localparam logic [7:0] ASCII_GAP  = 8'h2D;  // '-'
  localparam logic [6:0] AMINO_GAP  = 7'h2D;  // '-'
  localparam logic [6:0] AMINO_UNK  = 7'h58;  // 'X'
  localparam logic [6:0] AMINO_NONE = 7'h00;  // marker item

  // Number of bases of the current codon already held
  typedef enum logic [1:0] {
    POS_ZERO = 2'd0,
    POS_ONE  = 2'd1,
    POS_TWO  = 2'd2
  } pos_e;

  // 2-bit base code: T=0 C=1 A=2 G=3
  typedef struct packed {
    logic       ok;
    logic [1:0] code;
  } base_t;

  // Item held between the codon tracker and the lookup
  typedef struct packed {
    logic       is_codon;
    logic       last;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } codon_ev_t;

  // Result item ahead of the output register
  typedef struct packed {
    logic [6:0] amino;
    logic       valid_amino;
    logic       last;
  } amino_res_t;

  // Standard genetic code, index {first, second, third}; stops already 'Z'
  localparam logic [7:0] AMINO_TABLE [64] = '{
    "F","F","L","L","S","S","S","S","Y","Y","Z","Z","C","C","Z","W",
    "L","L","L","L","P","P","P","P","H","H","Q","Q","R","R","R","R",
    "I","I","I","M","T","T","T","T","N","N","K","K","S","S","R","R",
    "V","V","V","V","A","A","A","A","D","D","E","E","G","G","G","G"
  };

  // Map one ASCII byte to its base code, either case
  function automatic base_t base_code(input logic [7:0] b);
    base_t r;
    r = '{ok: 1'b1, code: 2'd0};
    case (b) inside
      8'h54, 8'h74: r.code = 2'd0;
      8'h43, 8'h63: r.code = 2'd1;
      8'h41, 8'h61: r.code = 2'd2;
      8'h47, 8'h67: r.code = 2'd3;
      default:      r.ok   = 1'b0;
    endcase
    return r;
  endfunction

  // Translate three bytes to one amino letter
  function automatic logic [6:0] translate(input logic [7:0] b0,
                                           input logic [7:0] b1,
                                           input logic [7:0] b2);
    base_t      c0;
    base_t      c1;
    base_t      c2;
    logic [7:0] letter;
    c0 = base_code(b0);
    c1 = base_code(b1);
    c2 = base_code(b2);
    letter = AMINO_TABLE[{c0.code, c1.code, c2.code}];
    if (!(c0.ok && c1.ok && c2.ok)) begin
      if (b0 == ASCII_GAP || b1 == ASCII_GAP || b2 == ASCII_GAP) begin
        return AMINO_GAP;
      end
      return AMINO_UNK;
    end
    return letter[6:0];
  endfunction

endpackage

/* rtl/core/ctat_codon_track.sv */
module ctat_codon_track (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            in_nuc_i,
  input  logic                  in_last_i,
  input  logic                  advance_i,   // next stage takes the held item
  output logic                  ev_valid_o,
  output ctat_pkg::codon_ev_t   ev_o
);
  import ctat_pkg::*;

  pos_e       pos_q, pos_d;
  logic [7:0] first_q, first_d;
  logic [7:0] second_q, second_d;
  logic       ev_valid_q, ev_valid_d;
  codon_ev_t  ev_q, ev_d;
  logic       accept;
  logic       emit;

  assign in_ready_o = !ev_valid_q || advance_i;
  assign accept     = in_valid_i && in_ready_o;

  // Step the codon position and build the item for the lookup
  always_comb begin
    pos_d    = pos_q;
    first_d  = first_q;
    second_d = second_q;
    emit     = 1'b0;
    ev_d     = ev_q;
    if (accept) begin
      case (pos_q)
        POS_TWO: begin
          emit  = 1'b1;
          ev_d  = '{is_codon: 1'b1, last: in_last_i,
                    b0: first_q, b1: second_q, b2: in_nuc_i};
          pos_d = POS_ZERO;
        end
        POS_ONE: begin
          second_d = in_nuc_i;
          emit     = in_last_i;
          pos_d    = in_last_i ? POS_ZERO : POS_TWO;
          ev_d     = '{is_codon: 1'b0, last: 1'b1,
                       b0: first_q, b1: in_nuc_i, b2: in_nuc_i};
        end
        default: begin
          first_d = in_nuc_i;
          emit    = in_last_i;
          pos_d   = in_last_i ? POS_ZERO : POS_ONE;
          ev_d    = '{is_codon: 1'b0, last: 1'b1,
                      b0: in_nuc_i, b1: second_q, b2: in_nuc_i};
        end
      endcase
    end
  end

  // Hold the item until the next stage takes it
  always_comb begin
    ev_valid_d = ev_valid_q;
    if (advance_i) begin
      ev_valid_d = 1'b0;
    end
    if (emit) begin
      ev_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= POS_ZERO;
      first_q    <= '0;
      second_q   <= '0;
      ev_valid_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      first_q    <= first_d;
      second_q   <= second_d;
      ev_valid_q <= ev_valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (emit) begin
      ev_q <= ev_d;
    end
  end

  assign ev_valid_o = ev_valid_q;
  assign ev_o       = ev_q;

endmodule

/* rtl/core/ctat_amino_lookup.sv */
module ctat_amino_lookup (
  input  ctat_pkg::codon_ev_t  ev_i,
  output ctat_pkg::amino_res_t res_o
);
  import ctat_pkg::*;

  // Translate a full codon; a marker carries no letter
  always_comb begin
    res_o.valid_amino = ev_i.is_codon;
    res_o.last        = ev_i.last;
    if (ev_i.is_codon) begin
      res_o.amino = translate(ev_i.b0, ev_i.b1, ev_i.b2);
    end else begin
      res_o.amino = AMINO_NONE;
    end
  end

endmodule

/* rtl/core/codon_to_amino_translator.sv */
// Codon to amino translator, standard genetic code.
// Input stream: one ASCII base per item on s_axis_tdata, s_axis_tlast marks
// the final base of a sequence. Every third base yields one amino letter on
// m_axis_tdata ('Z' for stop, 'X' for an unknown base, '-' when a gap base
// is in an unknown codon). A final base that ends a sequence mid-codon drops
// the partial codon and yields a marker item: tdata zero, tuser low, tlast high.
// m_axis_tuser is high on a translated codon; m_axis_tlast is high on the
// item caused by the final base.
// The codon register loads at the accepting edge of the third base; the table
// lookup sits between it and the output register, which loads the result
// once it is free or being drained. Throughput: one base per cycle while the
// receiver does not stall; the lookup between the two registers is combinational.
// A stalled receiver holds the output item; one more result can wait in the
// codon register, so s_axis_tready falls only when both are full.
// Reset clears the codon position and both stages; nothing is pending after.
module codon_to_amino_translator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] nucleotide
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] amino, [7] zero fill
  output logic       m_axis_tuser,   // [0] valid_amino
  output logic       m_axis_tlast
);
  import ctat_pkg::*;

`include "codon_to_amino_translator_defines.svh"

  logic       out_valid_q, out_valid_d;
  amino_res_t out_q;
  logic       out_ready;
  logic       ev_valid;
  codon_ev_t  ev;
  amino_res_t res;

  assign out_ready = !out_valid_q || m_axis_tready;

  ctat_codon_track u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_nuc_i   (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .advance_i  (out_ready),
    .ev_valid_o (ev_valid),
    .ev_o       (ev)
  );

  ctat_amino_lookup u_lookup (
    .ev_i  (ev),
    .res_o (res)
  );

  // Load the output register when it is free or being drained
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready) begin
      out_valid_d = ev_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && ev_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.amino};
  assign m_axis_tuser  = out_q.valid_amino;
  assign m_axis_tlast  = out_q.last;

  // A marker item carries no letter and always closes the sequence
  `CTAT_ASSERT_IMP(a_marker_form, m_axis_tvalid && !m_axis_tuser,
                   m_axis_tdata == 8'h00 && m_axis_tlast, "marker item malformed")

  // A translated codon always carries a 7-bit nonzero letter
  `CTAT_ASSERT_IMP(a_letter_form, m_axis_tvalid && m_axis_tuser,
                   m_axis_tdata != 8'h00 && !m_axis_tdata[7], "amino letter malformed")

  // With the output register empty the input side never stalls
  `CTAT_ASSERT_IMP(a_ready_free, !m_axis_tvalid, s_axis_tready,
                   "input stalled with empty output")

  // A held codon item reaches the output register once it drains
  `CTAT_ASSERT_NXT(a_ev_moves, ev_valid && out_ready, m_axis_tvalid,
                   "codon item lost between stages")

endmodule

/* tb/tb_codon_to_amino_translator.sv */
module tb_codon_to_amino_translator;
  import ctat_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RUN_ITEMS   = 344;  // random items per idle phase

  // One expected item on the amino stream
  typedef struct packed {
    logic [6:0] amino;
    logic       valid_amino;
    logic       last;
  } amino_item_t;

  // Tracks the codon being assembled and the amino items still owed
  class codon_scoreboard;
    string       code_table;
    logic [7:0]  held_first;
    logic [7:0]  held_second;
    pos_e        held_pos;
    amino_item_t owed_q[$];
    int unsigned fail_count;

    function new();
      // index first*16 + second*4 + third, bases T=0 C=1 A=2 G=3, stops as 'Z'
      code_table = {"FFLLSSSSYYZZCCZW", "LLLLPPPPHHQQRRRR",
                    "IIIMTTTTNNKKSSRR", "VVVVAAAADDEEGGGG"};
      held_first  = 8'h00;
      held_second = 8'h00;
      held_pos    = POS_ZERO;
      fail_count  = 0;
    endfunction

    function int base_index(logic [7:0] b);
      case (b)
        "T", "t": return 0;
        "C", "c": return 1;
        "A", "a": return 2;
        "G", "g": return 3;
        default:  return -1;
      endcase
    endfunction

    function logic [6:0] amino_of(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
      int  c0;
      int  c1;
      int  c2;
      byte letter;
      c0 = base_index(b0);
      c1 = base_index(b1);
      c2 = base_index(b2);
      // a codon with any non-ACGT byte is a gap if it holds a gap, else unknown
      if (c0 < 0 || c1 < 0 || c2 < 0) begin
        if (b0 == ASCII_GAP || b1 == ASCII_GAP || b2 == ASCII_GAP) begin
          return AMINO_GAP;
        end
        return AMINO_UNK;
      end
      letter = code_table.getc(c0 * 16 + c1 * 4 + c2);
      return letter[6:0];
    endfunction

    // Advance the codon on one accepted base
    function void note_base(logic [7:0] nuc, logic last);
      amino_item_t e;
      if (held_pos == POS_TWO) begin
        e.amino       = amino_of(held_first, held_second, nuc);
        e.valid_amino = 1'b1;
        e.last        = last;
        owed_q.push_back(e);
        held_pos = POS_ZERO;
        return;
      end
      if (held_pos == POS_ONE) begin
        held_second = nuc;
        held_pos    = POS_TWO;
      end else begin
        held_first = nuc;
        held_pos   = POS_ONE;
      end
      // end inside a codon: drop it and owe a marker
      if (last) begin
        e.amino       = AMINO_NONE;
        e.valid_amino = 1'b0;
        e.last        = 1'b1;
        owed_q.push_back(e);
        held_pos = POS_ZERO;
      end
    endfunction

    // Compare one accepted amino item with the oldest owed one
    function void check_amino(logic [7:0] data, logic user, logic last);
      amino_item_t e;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected amino item tdata=%h tuser=%b tlast=%b",
                 $time, data, user, last);
        fail_count++;
        return;
      end
      e = owed_q.pop_front();
      if (data !== {1'b0, e.amino}) begin
        $display("%0t: tdata mismatch expected=%h actual=%h", $time, {1'b0, e.amino}, data);
        fail_count++;
      end
      if (user !== e.valid_amino) begin
        $display("%0t: tuser mismatch expected=%b actual=%b", $time, e.valid_amino, user);
        fail_count++;
      end
      if (last !== e.last) begin
        $display("%0t: tlast mismatch expected=%b actual=%b", $time, e.last, last);
        fail_count++;
      end
    endfunction
  endclass

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tuser;
  logic       m_axis_tlast;

  int unsigned     src_idle    = 0;
  int unsigned     sink_stall  = 0;
  int unsigned     cycle_count = 0;
  codon_scoreboard sb          = new();

  codon_to_amino_translator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Stall the receiver at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall);
  end

  // Watch both handshakes and count cycles
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_base(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_amino(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end
    end
  end

  // Hold one base on the input until it is accepted
  task automatic send_base(input logic [7:0] nuc, input logic last);
    while ($urandom_range(0, 99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= nuc;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_str(input string s, input logic term);
    for (int i = 0; i < s.len(); i++) begin
      send_base(s.getc(i), term && (i == s.len() - 1));
    end
  endtask

  // Mostly real bases in either case, some gaps, ambiguity codes and raw bytes
  function automatic logic [7:0] pick_base();
    string bases;
    int    r;
    bases = "ACGTacgt";
    r     = $urandom_range(0, 99);
    if (r < 80) return bases.getc($urandom_range(0, 7));
    if (r < 88) return ASCII_GAP;
    if (r < 93) return (r[0]) ? "N" : "U";
    return 8'($urandom_range(0, 255));
  endfunction

  // Send random runs, well-formed most of the time
  task automatic send_runs(input int unsigned count);
    int unsigned sent;
    int unsigned len;
    logic        noisy;
    sent = 0;
    while (sent < count) begin
      len   = $urandom_range(1, 24);
      noisy = ($urandom_range(0, 9) == 0);
      for (int unsigned i = 0; i < len; i++) begin
        if (noisy) begin
          send_base(pick_base(), ($urandom_range(0, 3) == 0));
        end else begin
          send_base(pick_base(), (i == len - 1));
        end
      end
      sent += len;
    end
  endtask

  // Stop a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: start and stop codons, case mix, gap and unknown codons
    send_str("ATG", 1'b0);
    send_str("taa", 1'b0);
    send_str("TgA", 1'b0);
    send_str("A-G", 1'b0);
    send_str("ANG", 1'b0);
    send_base(8'hFF, 1'b0);
    send_base(8'h00, 1'b0);
    send_base(8'h80, 1'b0);
    // end on the first base, on the second, then on a full codon
    send_str("C", 1'b1);
    send_str("GG", 1'b1);
    send_str("TTT", 1'b1);

    // Random runs under each idle pattern
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          src_idle   = 0;
          sink_stall = 0;
        end
        1: begin
          src_idle   = 82;
          sink_stall = 0;
        end
        2: begin
          src_idle   = 0;
          sink_stall = 82;
        end
        default: begin
          src_idle   = 12;
          sink_stall = 12;
        end
      endcase
      send_runs(RUN_ITEMS);
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then watch for stray items
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    if (sb.fail_count == 0 && sb.owed_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
